// ----- rtl/core/pd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and hex helpers for the percent decoder.
// No dependencies; used by every module of the block.
package pd_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam logic [15:0] CapReset  = 16'd256;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChEnd     = 8'h00;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_DIG  = 2'd2
  } phase_e;

  // One classified source byte: up to three results, the final one may be
  // the terminator.
  typedef struct packed {
    logic [1:0]      num;
    logic            term;
    logic [2:0][7:0] data;
  } entry_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

// ----- rtl/core/pd_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts source bytes, tracks escapes, builds queue entries.
// Depends on pd_pkg.
module pd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_byte_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output pd_pkg::entry_t  q_entry_o
);

  pd_pkg::phase_e phase_q, phase_d;
  logic [7:0]     held_q, held_d;
  logic           accept;
  logic           hv;
  logic           do_tail;
  logic           tail_emit;
  logic           tail_term;
  logic [7:0]     tail_byte;
  pd_pkg::phase_e tail_phase;
  pd_pkg::entry_t ent;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign hv         = pd_pkg::is_hex(in_byte_i);

  // What the byte does on its own, once any pending escape is resolved.
  always_comb begin
    tail_emit  = 1'b1;
    tail_term  = 1'b0;
    tail_byte  = in_byte_i;
    tail_phase = pd_pkg::PH_IDLE;
    if (in_byte_i == pd_pkg::ChEnd) begin
      tail_term = 1'b1;
      tail_byte = pd_pkg::ChEnd;
    end else if (in_byte_i == pd_pkg::ChPercent) begin
      tail_emit  = 1'b0;
      tail_phase = pd_pkg::PH_PCT;
    end else if (in_byte_i == pd_pkg::ChPlus) begin
      tail_byte = pd_pkg::ChSpace;
    end
  end

  always_comb begin
    ent      = '0;
    do_tail  = 1'b0;
    phase_d  = phase_q;
    held_d   = held_q;
    case (phase_q)
      pd_pkg::PH_PCT: begin
        if (hv) begin
          held_d  = in_byte_i;
          phase_d = pd_pkg::PH_DIG;
        end else begin
          ent.data[0] = pd_pkg::ChPercent;
          ent.num     = 2'd1;
          do_tail     = 1'b1;
        end
      end
      pd_pkg::PH_DIG: begin
        held_d = 8'h00;
        if (hv) begin
          ent.data[0] = {pd_pkg::hex_nib(held_q), pd_pkg::hex_nib(in_byte_i)};
          ent.num     = 2'd1;
          phase_d     = pd_pkg::PH_IDLE;
        end else begin
          ent.data[0] = pd_pkg::ChPercent;
          ent.data[1] = held_q;
          ent.num     = 2'd2;
          do_tail     = 1'b1;
        end
      end
      default: begin
        do_tail = 1'b1;
      end
    endcase
    if (do_tail) begin
      phase_d = tail_phase;
      if (tail_term) begin
        held_d = 8'h00;
      end
      if (tail_emit) begin
        ent.data[ent.num] = tail_byte;
        ent.num           = ent.num + 2'd1;
        ent.term          = tail_term;
      end
    end
  end

  assign q_entry_o = ent;
  assign q_push_o  = accept && (ent.num != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pd_pkg::PH_IDLE;
      held_q  <= 8'h00;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// ----- rtl/core/pd_queue.sv -----
`timescale 1ns / 1ps
// Small register FIFO of classified entries between front and back.
// Depends on pd_pkg for the entry type.
module pd_queue #(
  parameter int unsigned Depth = pd_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pd_pkg::entry_t entry_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output pd_pkg::entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  pd_pkg::entry_t        mem_q [Depth];
  logic [PtrW-1:0]       wr_q, rd_q;
  logic [CntW-1:0]       cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/pd_back.sv -----
`timescale 1ns / 1ps
// Back end (needs pd_pkg): walks queue entries one result per cycle while
// not stalled, applies the capacity limit and drives the output register.
module pd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    cap_i,
  input  logic           q_valid_i,
  input  pd_pkg::entry_t q_head_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);

  logic [1:0]  idx_q;
  logic [15:0] cnt_q;
  logic [15:0] limit;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic        is_final;
  logic        is_term;
  logic        drop;
  logic        can_load;
  logic        fire;
  logic        load;

  assign limit    = (cap_i == 16'd0) ? 16'd0 : cap_i - 16'd1;
  assign is_final = (idx_q == q_head_i.num - 2'd1);
  assign is_term  = q_head_i.term && is_final;
  // Data beats past capacity are consumed without an output beat.
  assign drop     = !is_term && !(cnt_q < limit);
  assign can_load = !out_valid_q || !out_stall_i;
  assign fire     = q_valid_i && (drop || can_load);
  assign load     = fire && !drop;
  assign q_pop_o  = fire && is_final;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= is_term ? pd_pkg::ChEnd : q_head_i.data[idx_q];
      out_last_q <= is_term;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      cnt_q       <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        idx_q <= is_final ? 2'd0 : idx_q + 2'd1;
      end
      if (load) begin
        cnt_q <= is_term ? 16'd0 : cnt_q + 16'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- rtl/core/percent_decoder.sv -----
`timescale 1ns / 1ps
// Streaming URL / form-urlencoded percent decoder, top level.
// Depends on pd_pkg, pd_front, pd_queue and pd_back.
//
// Input channel (in_valid_i / in_stall_o / in_byte_i): one source byte per
// beat; byte 0 ends the string. "%hh" decodes to a byte, '+' to a space,
// anything else is copied. A broken escape falls back to literal bytes.
// Output channel (out_valid_o / out_stall_i / out_byte_o / out_last_o): one
// decoded byte per beat; the terminator beat carries byte 0 and last = 1.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes the
// destination capacity (terminator included); data bytes past capacity-1
// are dropped. Always ready; write only while the block is idle.
// A result is registered in a queue entry, then in the output register.
// Throughput: one input beat per cycle while the receiver does not stall
// and each byte yields at most one result; the back end moves one result
// per cycle, so bytes that yield two or three (broken escape) fill the
// queue and then stall the input.
// Reset clears the escape state, the output count and the queue, and sets
// capacity to 256. When the receiver stalls, the output register holds and
// the queue fills; the input stalls once the queue is full.
module percent_decoder #(
  parameter int unsigned QueueDepth = pd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0]    cap_q;
  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  pd_pkg::entry_t q_entry;
  pd_pkg::entry_t q_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= pd_pkg::CapReset;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  pd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  pd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  pd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_q),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule
